// ===== rtl/tcw_pkg.sv =====
// Package for the text console writer.
// Holds the command codes, character constants and the result record.
// No dependencies.
package tcw_pkg;

  localparam int CELL_W  = 16;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 8;
  localparam int OROW_W  = 5;
  localparam int OCOL_W  = 7;

  localparam logic [CHAR_W-1:0]  NEWLINE_CHAR = 8'd10;
  localparam logic [CHAR_W-1:0]  SPACE_CHAR   = 8'd32;
  localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'd7;

  typedef enum logic [1:0] {
    CMD_PUT   = 2'd0,
    CMD_READ  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef struct packed {
    logic              scrolled;
    logic [OCOL_W-1:0] cursor_col;
    logic [OROW_W-1:0] cursor_row;
    logic [CELL_W-1:0] cell_entry;
  } result_t;

endpackage

// ===== rtl/tcw_screen_mem.sv =====
// Screen cell store: one write port and one read port, read data registered.
// Depends on tcw_pkg for the cell width.
module tcw_screen_mem
  import tcw_pkg::*;
#(
  parameter int AW    = 12,
  parameter int DEPTH = 3200
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [CELL_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [CELL_W-1:0] rdata
);

  logic [CELL_W-1:0] cells [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      cells[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= cells[raddr];
    end
  end

endmodule

// ===== rtl/tcw_ctrl.sv =====
// Command sequencer: cursor, ring offset, fill and scroll sweeps.
// Depends on tcw_pkg; drives the ports of tcw_screen_mem.
module tcw_ctrl
  import tcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25,
  parameter int RW   = 5,
  parameter int CW   = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [COLOR_W-1:0] text_colour,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_command,
  input  logic [CHAR_W-1:0]  in_char,
  input  logic [OROW_W-1:0]  in_row,
  input  logic [OCOL_W-1:0]  in_col,
  output logic               res_valid,
  input  logic               res_ready,
  output result_t            res,
  output logic               mem_we,
  output logic [RW+CW-1:0]   mem_waddr,
  output logic [CELL_W-1:0]  mem_wdata,
  output logic               mem_re,
  output logic [RW+CW-1:0]   mem_raddr,
  input  logic [CELL_W-1:0]  mem_rdata
);

  typedef enum logic [2:0] {
    ST_FILL,
    ST_IDLE,
    ST_EXEC,
    ST_SCROLL,
    ST_RDATA,
    ST_DONE
  } state_t;

  localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
  localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);
  localparam logic [RW:0]   ROWS_EXT = (RW + 1)'(ROWS);

  state_t              state;
  cmd_t                cmd;
  logic [CHAR_W-1:0]   ch;
  logic [OROW_W-1:0]   rd_row;
  logic [OCOL_W-1:0]   rd_col;
  logic [RW-1:0]       cur_row;
  logic [CW-1:0]       cur_col;
  logic [RW-1:0]       top;
  logic [RW-1:0]       sw_row;
  logic [CW-1:0]       sw_col;
  logic                fill_init;
  logic [CELL_W-1:0]   rd_cell;
  logic                scrolled;

  logic [RW-1:0]       sel_row;
  logic [RW:0]         psum;
  logic [RW-1:0]       phys_row;
  logic                in_range;
  logic                is_newline;
  logic                wrap;
  logic [CELL_W-1:0]   blank;

  // Screen row to storage row: the ring offset added modulo ROWS.
  always_comb begin
    sel_row  = (cmd == CMD_READ) ? RW'(rd_row) : cur_row;
    psum     = {1'b0, sel_row} + {1'b0, top};
    phys_row = (psum >= ROWS_EXT) ? RW'(psum - ROWS_EXT) : RW'(psum);
  end

  assign in_range   = (32'(rd_row) < ROWS) && (32'(rd_col) < COLS);
  assign is_newline = (ch == NEWLINE_CHAR);
  assign wrap       = is_newline || (cur_col == LAST_COL);
  assign blank      = {text_colour, SPACE_CHAR};

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {phys_row, cur_col};
    mem_wdata = {text_colour, ch};
    unique case (state)
      ST_FILL: begin
        // The pass after reset always blanks in the reset colour.
        mem_we    = 1'b1;
        mem_waddr = {sw_row, sw_col};
        mem_wdata = fill_init ? {RESET_COLOR, SPACE_CHAR} : blank;
      end
      ST_SCROLL: begin
        mem_we    = 1'b1;
        mem_waddr = {top, sw_col};
        mem_wdata = blank;
      end
      ST_EXEC: begin
        mem_we = (cmd == CMD_PUT) && !is_newline;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  assign mem_re    = (state == ST_EXEC) && (cmd == CMD_READ) && in_range;
  assign mem_raddr = {phys_row, CW'(rd_col)};

  assign in_ready       = (state == ST_IDLE);
  assign res_valid      = (state == ST_DONE);
  assign res.cell_entry = rd_cell;
  assign res.cursor_row = OROW_W'(cur_row);
  assign res.cursor_col = OCOL_W'(cur_col);
  assign res.scrolled   = scrolled;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_FILL;
      cur_row   <= '0;
      cur_col   <= '0;
      top       <= '0;
      sw_row    <= '0;
      sw_col    <= '0;
      fill_init <= 1'b1;
    end else begin
      unique case (state)
        ST_FILL: begin
          if (sw_col == LAST_COL) begin
            sw_col <= '0;
            if (sw_row == LAST_ROW) begin
              state <= fill_init ? ST_IDLE : ST_DONE;
            end else begin
              sw_row <= sw_row + 1'b1;
            end
          end else begin
            sw_col <= sw_col + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            cmd    <= cmd_t'(in_command);
            ch     <= in_char;
            rd_row <= in_row;
            rd_col <= in_col;
            state  <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          rd_cell  <= '0;
          scrolled <= 1'b0;
          unique case (cmd)
            CMD_PUT: begin
              if (!wrap) begin
                cur_col <= cur_col + 1'b1;
                state   <= ST_DONE;
              end else begin
                cur_col <= '0;
                if (cur_row == LAST_ROW) begin
                  scrolled <= 1'b1;
                  sw_col   <= '0;
                  state    <= ST_SCROLL;
                end else begin
                  cur_row <= cur_row + 1'b1;
                  state   <= ST_DONE;
                end
              end
            end
            CMD_READ: begin
              state <= in_range ? ST_RDATA : ST_DONE;
            end
            CMD_CLEAR: begin
              top       <= '0;
              sw_row    <= '0;
              sw_col    <= '0;
              fill_init <= 1'b0;
              state     <= ST_FILL;
            end
            default: begin
              state <= ST_DONE;
            end
          endcase
        end
        ST_SCROLL: begin
          // The old top storage row becomes the blank bottom row.
          if (sw_col == LAST_COL) begin
            top   <= (top == LAST_ROW) ? '0 : top + 1'b1;
            state <= ST_DONE;
          end else begin
            sw_col <= sw_col + 1'b1;
          end
        end
        ST_RDATA: begin
          rd_cell <= mem_rdata;
          state   <= ST_DONE;
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/text_console_writer.sv =====
// Top level of the text console writer: stream ports, colour register, result register.
// Depends on tcw_pkg, tcw_ctrl and tcw_screen_mem.
//
// A text screen of ROWS x COLS cells, each a character in the low byte and
// its colour in the high byte, with a write cursor. Every item gives exactly
// one result item carrying the cursor after the item, a read cell (zero for
// other commands) and a scroll flag. The block works on one item at a time
// and the cell store has a single write port, which sets the timing: a put
// or a newline runs through execute and done, a read adds a read-data step,
// a put that leaves the bottom row adds a sweep that blanks the new bottom
// row (the screen is kept as a ring of rows, so only one row is written),
// and a clear screen sweeps the whole screen. After reset a clearing pass
// over all ROWS*COLS cells (2000 at the default size) fills the screen with
// blanks in colour 7 before the first item is taken; the colour register
// can be written meanwhile. A finished result sits in an output register,
// so the next item is accepted while it waits to be taken. Rows and columns
// on the ports are 5 and 7 bits wide; cursor outputs carry the low bits.
module text_console_writer
  import tcw_pkg::*;
#(
  parameter int COLS = 80,
  parameter int ROWS = 25
) (
  input  logic        clk,
  input  logic        rst,
  // Input item stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,  // char_code[7:0], read_row[12:8], read_col[19:13]
  input  logic [1:0]  s_tuser,  // command[1:0]
  // Result item stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // cell_entry[15:0], cursor_row[20:16],
                                // cursor_col[27:21], scrolled[28]
  // Configuration port; text_colour at byte address 0.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int AW    = RW + CW;
  localparam int DEPTH = ROWS * (1 << CW);

  logic [COLOR_W-1:0] text_colour;
  logic               res_valid;
  logic               res_ready;
  result_t            res;
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [CELL_W-1:0]  mem_wdata;
  logic               mem_re;
  logic [AW-1:0]      mem_raddr;
  logic [CELL_W-1:0]  mem_rdata;

  // Colour register. Word-aligned decode: the low address bits are ignored.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {24'b0, text_colour} : 32'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_colour <= RESET_COLOR;
    end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
      text_colour <= pwdata[COLOR_W-1:0];
    end
  end

  tcw_ctrl #(
    .COLS (COLS),
    .ROWS (ROWS),
    .RW   (RW),
    .CW   (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .text_colour (text_colour),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_command  (s_tuser),
    .in_char     (s_tdata[7:0]),
    .in_row      (s_tdata[12:8]),
    .in_col      (s_tdata[19:13]),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .mem_we      (mem_we),
    .mem_waddr   (mem_waddr),
    .mem_wdata   (mem_wdata),
    .mem_re      (mem_re),
    .mem_raddr   (mem_raddr),
    .mem_rdata   (mem_rdata)
  );

  tcw_screen_mem #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: loads when empty or when its item is being taken.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {3'b0, res};
    end
  end

endmodule

// ===== tb/sv/text_console_writer_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the text console writer: drives command items and colour
// register writes, predicts every result item from a screen model and checks each field.
// Depends on tcw_pkg and the text_console_writer RTL.
module text_console_writer_test;
  import tcw_pkg::*;

  localparam int COLS = 80;
  localparam int ROWS = 25;
  localparam logic [2:0] TEXT_COLOUR_ADDR = 3'd0;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 100;
  // A clear screen is the slowest item; this covers it with room to spare.
  localparam int SETTLE_CYCLES = 2100;

  // Screen model plus the queue of result items it has predicted. The screen is
  // kept as a ring of rows, just like the block, so a scroll blanks one row only.
  class console_tracker;
    bit [15:0]   cells [ROWS*COLS];
    int unsigned cur_row;
    int unsigned cur_col;
    int unsigned top_row;
    bit [7:0]    colour;
    result_t     expected_q [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned scrolls;
    int unsigned clears;
    int unsigned cell_reads;

    function new();
      colour     = RESET_COLOR;
      cur_row    = 0;
      cur_col    = 0;
      mismatches = 0;
      checked    = 0;
      scrolls    = 0;
      clears     = 0;
      cell_reads = 0;
      blank_screen();
    endfunction

    function void blank_screen();
      foreach (cells[i]) cells[i] = {colour, SPACE_CHAR};
      top_row = 0;
    endfunction

    // Moves to column 0 of the next row; from the bottom row the screen scrolls
    // instead, and the storage row that was on top becomes the blank bottom row.
    function bit next_line();
      cur_col = 0;
      if (cur_row + 1 >= ROWS) begin
        for (int c = 0; c < COLS; c++) cells[top_row*COLS + c] = {colour, SPACE_CHAR};
        top_row = (top_row + 1) % ROWS;
        scrolls++;
        return 1'b1;
      end
      cur_row++;
      return 1'b0;
    endfunction

    function void take_item(cmd_t cmd, bit [7:0] ch, bit [4:0] rrow, bit [6:0] rcol);
      result_t want;
      want = '0;
      case (cmd)
        CMD_PUT: begin
          if (ch == NEWLINE_CHAR) begin
            want.scrolled = next_line();
          end else begin
            cells[((cur_row + top_row) % ROWS)*COLS + cur_col] = {colour, ch};
            cur_col++;
            // Writing the last column wraps at once.
            if (cur_col >= COLS) want.scrolled = next_line();
          end
        end
        CMD_READ: begin
          // Reads outside the screen return zero.
          if (rrow < ROWS && rcol < COLS) begin
            want.cell_entry = cells[((rrow + top_row) % ROWS)*COLS + rcol];
            cell_reads++;
          end
        end
        CMD_CLEAR: begin
          blank_screen();
          clears++;
        end
        default: begin
        end
      endcase
      want.cursor_row = 5'(cur_row);
      want.cursor_col = 7'(cur_col);
      expected_q.push_back(want);
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result item %h arrived with nothing pending", got);
        mismatches++;
        return;
      end
      want = expected_q.pop_front();
      checked++;
      check_field("cell_entry", want.cell_entry, got.cell_entry);
      check_field("cursor_row", 16'(want.cursor_row), 16'(got.cursor_row));
      check_field("cursor_col", 16'(want.cursor_col), 16'(got.cursor_col));
      check_field("scrolled", 16'(want.scrolled), 16'(got.scrolled));
    endfunction
  endclass

  // Every block input starts at a known value.
  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;  // char_code[7:0], read_row[12:8], read_col[19:13]
  logic [1:0]  s_tuser  = '0;  // command[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // cell_entry[15:0], cursor_row[20:16], cursor_col[27:21],
                               // scrolled[28]
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  console_tracker tracker = new();

  // Knobs for the idling of each side; the main sequence turns them off for
  // some phases so that there are stretches at full rate as well.
  bit          source_gaps = 1'b1;
  bit          sink_stalls = 1'b1;
  int unsigned stall_left  = 0;
  int unsigned items_sent  = 0;
  int unsigned colour_writes = 0;

  text_console_writer #(
    .COLS(COLS),
    .ROWS(ROWS)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 0;
  end

  // Result side back-pressure: mostly ready, with short stalls and now and then
  // a long one. While stall_left counts down, tready simply stays low.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else if (!sink_stalls || $urandom_range(0, 99) < 70) begin
      m_tready <= 1'b1;
    end else begin
      m_tready   <= 1'b0;
      stall_left <= ($urandom_range(0, 9) < 9) ? $urandom_range(0, 2) : $urandom_range(5, 40);
    end
  end

  // Both handshakes are sampled here, at the edge, with the values the block saw.
  // An accepted item feeds the model; an accepted result is checked against it.
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      tracker.take_item(cmd_t'(s_tuser), s_tdata[7:0], s_tdata[12:8], s_tdata[19:13]);
    if (!rst && m_tvalid && m_tready)
      tracker.check_result(result_t'(m_tdata[28:0]));
  end

  // Presents one item, after a random gap, and returns at the edge that takes it.
  // Valid is only lowered when a gap follows, so it never toggles within a step.
  task automatic send_item(input cmd_t cmd, input logic [7:0] ch,
                           input logic [4:0] row, input logic [6:0] col);
    int unsigned gap;
    gap = 0;
    if (source_gaps) begin
      gap = $urandom_range(0, 99);
      gap = (gap < 55) ? 0 : (gap < 90) ? $urandom_range(1, 3) : $urandom_range(5, 30);
    end
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {4'd0, col, row, ch};
    do @(posedge clk); while (!s_tready);
    if (cmd != CMD_NOP) items_sent++;
  endtask

  // Reads lean towards the row being written and the top and bottom rows, where
  // scrolling shows, with a share of addresses off the screen.
  task automatic send_read();
    int unsigned pick;
    logic [4:0]  row;
    logic [6:0]  col;
    pick = $urandom_range(0, 99);
    row  = 5'($urandom_range(0, ROWS - 1));
    col  = 7'($urandom_range(0, COLS - 1));
    if (pick < 45) row = 5'(tracker.cur_row);
    else if (pick < 55) row = pick[0] ? 5'(ROWS - 1) : 5'd0;
    else if (pick < 78) row = pick < 70 ? row : 5'($urandom_range(ROWS, 31));
    else if (pick < 86) col = 7'($urandom_range(COLS, 127));
    send_item(CMD_READ, 8'($urandom), row, col);
  endtask

  // Stops offering items and waits until every predicted result has been taken.
  // The first edge lets the monitor register an item accepted at this very edge.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (tracker.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Setup cycle, then access cycle; the register takes the value at the edge
  // where the access phase meets pready.
  task automatic write_colour(input logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= TEXT_COLOUR_ADDR;
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    tracker.colour = value;
    colour_writes++;
  endtask

  // Random text: runs of characters, mostly short, some long enough to wrap a
  // line, usually ended by a newline, then a few reads, and now and then an
  // unused command or a clear. Enough newlines arrive to reach the bottom row
  // early, so most of the run exercises scrolling through the ring of rows.
  task automatic run_phase(input int unsigned quota);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned run_len;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      pick    = $urandom_range(0, 99);
      run_len = (pick < 80) ? $urandom_range(0, 8)
              : (pick < 90) ? $urandom_range(10, 30) : $urandom_range(75, 90);
      repeat (run_len) send_item(CMD_PUT, 8'($urandom), 5'($urandom), 7'($urandom));
      if ($urandom_range(0, 99) < 85)
        send_item(CMD_PUT, NEWLINE_CHAR, 5'($urandom), 7'($urandom));
      repeat ($urandom_range(0, 3)) send_read();
      if ($urandom_range(0, 99) < 5)
        send_item(CMD_NOP, 8'($urandom), 5'($urandom), 7'($urandom));
      if ($urandom_range(0, 99) < 6)
        send_item(CMD_CLEAR, 8'($urandom), 5'($urandom), 7'($urandom));
    end
  endtask

  initial begin
    bit [7:0] colours [PHASES];
    colours = '{8'h00, 8'hFF, 8'h3C, 8'h0F, 8'($urandom), 8'hF0, RESET_COLOR};

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed part, in the reset colour. The first item waits out the clearing
    // pass after reset. Corners of the screen, then reads off the screen in row,
    // in column and in both with every address bit set.
    send_item(CMD_READ, 8'h00, 5'd0, 7'd0);
    send_item(CMD_READ, 8'hFF, 5'(ROWS - 1), 7'(COLS - 1));
    send_item(CMD_READ, 8'h00, 5'(ROWS), 7'd0);
    send_item(CMD_READ, 8'h00, 5'd0, 7'(COLS));
    send_item(CMD_READ, 8'h00, 5'h1F, 7'h7F);
    // The unused command must leave everything alone, even with all fields set.
    send_item(CMD_NOP, 8'hFF, 5'h1F, 7'h7F);
    // Extreme character codes, then a newline after text and one on an empty line.
    send_item(CMD_PUT, 8'h00, 5'd0, 7'd0);
    send_item(CMD_PUT, 8'hFF, 5'h1F, 7'h7F);
    send_item(CMD_PUT, NEWLINE_CHAR, 5'd0, 7'd0);
    send_item(CMD_PUT, NEWLINE_CHAR, 5'd0, 7'd0);
    send_item(CMD_READ, 8'h00, 5'd0, 7'd0);
    send_item(CMD_READ, 8'h00, 5'd0, 7'd1);
    send_item(CMD_READ, 8'h00, 5'd0, 7'd2);

    // All-ones colour: written cells and then a clear must carry it, while the
    // cursor stays where it was across the clear.
    drain();
    write_colour(8'hFF);
    send_item(CMD_PUT, 8'h41, 5'd0, 7'd0);
    send_item(CMD_PUT, 8'hAA, 5'd0, 7'd0);
    send_item(CMD_PUT, 8'h55, 5'd0, 7'd0);
    send_item(CMD_READ, 8'h00, 5'd2, 7'd1);
    send_item(CMD_CLEAR, 8'h00, 5'd0, 7'd0);
    send_item(CMD_READ, 8'h00, 5'd2, 7'd1);
    send_item(CMD_READ, 8'h00, 5'(ROWS - 1), 7'(COLS - 1));
    send_item(CMD_NOP, 8'h00, 5'd0, 7'd0);

    // All-zeros colour on a freshly cleared screen.
    drain();
    write_colour(8'h00);
    send_item(CMD_PUT, 8'h78, 5'd0, 7'd0);
    send_item(CMD_READ, 8'h00, 5'd2, 7'd3);

    // Random part: one colour per phase, written while the block is idle. Some
    // phases run one or both sides without idling.
    for (int p = 0; p < PHASES; p++) begin
      drain();
      write_colour(colours[p]);
      source_gaps = (p != 2 && p != 5);
      sink_stalls = (p != 3 && p != 5);
      run_phase(PHASE_ITEMS);
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d items with %0d colour settings; %0d results checked, %0d on-screen reads.",
             items_sent, colour_writes, tracker.checked, tracker.cell_reads);
    $display("The screen scrolled %0d times and was cleared %0d times.",
             tracker.scrolls, tracker.clears);
    if (tracker.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #8_000_000;
    $error("run timed out with %0d results still pending", tracker.expected_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
